// ----- design/deq_pkg.sv -----
package deq_pkg;

  localparam int unsigned Depth      = 64;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned IdxW       = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW       = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    OP_PUSH_BACK = 2'd0,
    OP_POP_FRONT = 2'd1,
    OP_POP_BACK  = 2'd2,
    OP_PEEK_BACK = 2'd3
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  typedef struct packed {
    deq_op_e            operation;
    logic signed [31:0] push_value;
  } deq_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    deq_status_e        status;
    logic               now_empty;
  } deq_rsp_t;

  typedef struct packed {
    logic                  we;
    logic                  re;
    logic [IdxW-1:0]       addr;
    logic [ValueWidth-1:0] wdata;
  } deq_mem_req_t;

  // Ring position: front + offset, wrapped at Depth (sum stays below 2*Depth).
  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] front,
                                               input logic [IdxW-1:0] offset);
    logic [IdxW:0] sum;
    sum = {1'b0, front} + {1'b0, offset};
    if (sum >= (IdxW + 1)'(Depth)) begin
      sum = sum - (IdxW + 1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

// ----- design/double_ended_queue_core.sv -----
// Bounded double-ended queue over a ring buffer of Depth entries.
//
// Request channel: drive req_i (operation, push_value) and raise start; the
// transaction is taken at a rising edge with start high and busy low. busy
// stays low, so a new request may be issued in every cycle.
//
// Result channel: valid_o is high for exactly one cycle, in the cycle after the
// request was taken, with rsp_o carrying read_value, status and now_empty.
// The receiver cannot stall; a result must be sampled in that cycle.
//
// Throughput is one request per cycle for every operation, as set by the
// single-port entry memory: a push writes it in the accept cycle, a pop or
// peek reads it then and the registered read data forms the result.
// Pointers and count update at the accept edge, so the next request always
// sees the updated state and no forwarding is needed.
//
// Reset clears the front pointer and the item count; the entry memory is not
// cleared and needs no clearing pass. A push onto a full store is dropped
// with status full; a pop or peek on an empty store returns 0, status empty.
module double_ended_queue_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::deq_req_t  req_i,
  output logic               valid_o,
  output deq_pkg::deq_rsp_t  rsp_o
);
  import deq_pkg::*;

  deq_mem_req_t          mem_req;
  logic [ValueWidth-1:0] rdata;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  deq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (req_i),
    .rdata_i   (rdata),
    .mem_req_o (mem_req),
    .valid_o   (valid_o),
    .rsp_o     (rsp_o)
  );

  deq_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (rdata)
  );

endmodule

// ----- design/deq_store.sv -----
module deq_store (
  input  logic                           clk_i,
  input  deq_pkg::deq_mem_req_t          mem_req_i,
  output logic [deq_pkg::ValueWidth-1:0] rdata_o
);
  import deq_pkg::*;

  logic [ValueWidth-1:0] mem [Depth];
  logic [ValueWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.addr] <= mem_req_i.wdata;
    end
    if (mem_req_i.re) begin
      rdata_q <= mem[mem_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/deq_ctrl.sv -----
module deq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  deq_pkg::deq_req_t              req_i,
  input  logic [deq_pkg::ValueWidth-1:0] rdata_i,
  output deq_pkg::deq_mem_req_t          mem_req_o,
  output logic                           valid_o,
  output deq_pkg::deq_rsp_t              rsp_o
);
  import deq_pkg::*;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic            valid_q;
  logic            rd_q, rd_d;
  deq_status_e     status_q, status_d;
  logic            empty_q;
  logic signed [ValueWidth-1:0] rvalue;

  always_comb begin
    front_d         = front_q;
    count_d         = count_q;
    status_d        = ST_OK;
    rd_d            = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = front_q;
    mem_req_o.wdata = ValueWidth'(req_i.push_value);
    if (accept_i) begin
      unique case (req_i.operation)
        OP_PUSH_BACK: begin
          if (count_q == CntW'(Depth)) begin
            status_d = ST_FULL;
          end else begin
            mem_req_o.we   = 1'b1;
            mem_req_o.addr = ring_pos(front_q, count_q[IdxW-1:0]);
            count_d        = count_q + CntW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            mem_req_o.re = 1'b1;
            rd_d         = 1'b1;
            front_d      = ring_pos(front_q, IdxW'(1));
            count_d      = count_q - CntW'(1);
          end
        end
        OP_POP_BACK, OP_PEEK_BACK: begin
          if (count_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            mem_req_o.re   = 1'b1;
            rd_d           = 1'b1;
            mem_req_o.addr = ring_pos(front_q, IdxW'(count_q - CntW'(1)));
            if (req_i.operation == OP_POP_BACK) begin
              count_d = count_q - CntW'(1);
            end
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      valid_q <= accept_i;
    end
  end

  // Result side fields: held only with the strobe, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q     <= rd_d;
      status_q <= status_d;
      empty_q  <= (count_d == '0);
    end
  end

  assign rvalue           = rdata_i;
  assign valid_o          = valid_q;
  assign rsp_o.read_value = rd_q ? 32'(rvalue) : 32'sd0;
  assign rsp_o.status     = status_q;
  assign rsp_o.now_empty  = empty_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("item count beyond depth");

  a_one_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> valid_o)
    else $error("accepted transaction gave no result");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> !valid_o)
    else $error("result without transaction");

  a_full_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && req_i.operation == OP_PUSH_BACK && count_q == CntW'(Depth))
    |=> (rsp_o.status == ST_FULL && $stable(count_q)))
    else $error("push onto full store not flagged");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && req_i.operation != OP_PUSH_BACK && count_q == '0)
    |=> (rsp_o.status == ST_EMPTY && rsp_o.read_value == 32'sd0))
    else $error("read of empty store not flagged");

endmodule
